// ----- rtl/core/iplc_pkg.sv -----
// Shared types, widths, format codes and the format table of the plane layout calculator.
package iplc_pkg;

    localparam int MAX_PLANES_DEF = 3;

    localparam int FMT_W     = 32;
    localparam int DIM_W     = 14;
    localparam int ALIGN_W   = 13;
    localparam int BPL_W     = 16;
    localparam int STRIDE_W  = 17;
    localparam int OFFSET_W  = 30;
    localparam int PLANE_W   = 2;
    localparam int COUNT_W   = 2;
    localparam int BITS_W    = 6;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    // Four-character codes; the first character sits in the lowest byte, so the
    // string literals below are written back to front.
    localparam logic [FMT_W-1:0] FCC_UYVY = "YVYU";
    localparam logic [FMT_W-1:0] FCC_VYUY = "YUYV";
    localparam logic [FMT_W-1:0] FCC_YUYV = "VYUY";
    localparam logic [FMT_W-1:0] FCC_YVYU = "UYVY";
    localparam logic [FMT_W-1:0] FCC_NV16 = "61VN";
    localparam logic [FMT_W-1:0] FCC_NV61 = "16VN";
    localparam logic [FMT_W-1:0] FCC_422P = "P224";
    localparam logic [FMT_W-1:0] FCC_NV12 = "21VN";
    localparam logic [FMT_W-1:0] FCC_NM12 = "21MN";
    localparam logic [FMT_W-1:0] FCC_NV21 = "12VN";
    localparam logic [FMT_W-1:0] FCC_NM21 = "12MN";
    localparam logic [FMT_W-1:0] FCC_YM12 = "21MY";
    localparam logic [FMT_W-1:0] FCC_RGB4 = "4BGR";
    localparam logic [FMT_W-1:0] FCC_BGR4 = "4RGB";
    localparam logic [FMT_W-1:0] FCC_RGBP = "PBGR";

    typedef struct packed {
        logic                       known;
        logic [COUNT_W-1:0]         phys;
        logic [COUNT_W-1:0]         comps;
        logic [2:0][BITS_W-1:0]     bits;
        logic [2:0]                 div2;
    } fmt_t;

    function automatic fmt_t make_fmt(input logic [COUNT_W-1:0] phys,
                                      input logic [COUNT_W-1:0] comps,
                                      input logic [BITS_W-1:0]  b0,
                                      input logic [BITS_W-1:0]  b1,
                                      input logic [BITS_W-1:0]  b2,
                                      input logic [2:0]         div2);
        fmt_t f;
        f.known = 1'b1;
        f.phys  = phys;
        f.comps = comps;
        f.bits  = {b2, b1, b0};
        f.div2  = div2;
        return f;
    endfunction

    function automatic fmt_t lookup_fmt(input logic [FMT_W-1:0] code);
        fmt_t f;
        f = '0;
        case (code)
            FCC_UYVY, FCC_VYUY, FCC_YUYV, FCC_YVYU, FCC_RGBP: begin
                f = make_fmt(2'd1, 2'd1, 6'd16, 6'd0, 6'd0, 3'b000);
            end
            FCC_NV16, FCC_NV61: begin
                f = make_fmt(2'd1, 2'd2, 6'd8, 6'd8, 6'd0, 3'b000);
            end
            FCC_422P: begin
                f = make_fmt(2'd1, 2'd3, 6'd8, 6'd4, 6'd4, 3'b000);
            end
            FCC_NV12, FCC_NV21: begin
                f = make_fmt(2'd1, 2'd2, 6'd8, 6'd4, 6'd0, 3'b010);
            end
            FCC_NM12, FCC_NM21: begin
                f = make_fmt(2'd2, 2'd2, 6'd8, 6'd4, 6'd0, 3'b010);
            end
            FCC_YM12: begin
                f = make_fmt(2'd3, 2'd3, 6'd8, 6'd2, 6'd2, 3'b110);
            end
            FCC_RGB4, FCC_BGR4: begin
                f = make_fmt(2'd1, 2'd1, 6'd32, 6'd0, 6'd0, 3'b000);
            end
            default: begin
                f = '0;
            end
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/core/image_plane_layout_calculator.sv -----
// Top level of the image plane layout calculator: sequencer, plane arithmetic and output register.
//
// Usage: a request on the s_ channel carries a fourcc code, an image width and
// an image height. The block looks the code up in its table of fifteen YUV and
// RGB formats and returns one result on the m_ channel per component plane
// (at most MAX_PLANES), each with byte offset, bytes per line, stride and line
// count. m_tlast marks the final result of a request. An unknown code returns a
// single result with m_tuser set and all other fields zero.
// The cfg channel writes the stride alignment in bytes (zero acts as one); it
// is always ready. The user must write it only while no request is in flight;
// the block itself does not enforce this. Throughput: one request at a time;
// s_tready is high only while idle. Each plane passes through the start,
// divide, multiply and emit states; while dividing, the shared bit-serial
// remainder unit finds the remainder by which the line length is rounded up
// to the alignment.
// Reset (aresetn low, synchronous) empties the output register, returns the
// sequencer to idle and sets the alignment back to one. When the receiver
// stalls, the current result holds on m_tdata and the next plane waits for
// the output register to drain.
module image_plane_layout_calculator #(
    parameter int MAX_PLANES = iplc_pkg::MAX_PLANES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_format[31:0], image_width[45:32], image_height[59:46], zero fill
    input  logic [iplc_pkg::IN_TDATA_W-1:0]   s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // plane_index[1:0], byte_offset[31:2], bytes_per_line[47:32],
    // line_stride[64:48], line_count[78:65], physical_planes[80:79],
    // component_planes[82:81], zero fill
    output logic [iplc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // unknown_format[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iplc_pkg::ALIGN_W-1:0]      cfg_data
);
    import iplc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_DIV   = 6'b000100,
        S_MUL   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_ERR   = 6'b100000
    } state_t;

    localparam logic [2:0] PLANE_CAP = 3'(MAX_PLANES);
    localparam int PROD_W = STRIDE_W + DIM_W;

    state_t                 state_reg, state_next;
    logic [ALIGN_W-1:0]     align_reg;
    fmt_t                   fmt_reg, fmt_next;
    logic [DIM_W-1:0]       width_reg, width_next;
    logic [DIM_W-1:0]       height_reg, height_next;
    logic [PLANE_W-1:0]     plane_reg, plane_next;
    logic [BPL_W-1:0]       bpl_reg, bpl_next;
    logic [DIM_W-1:0]       lines_reg, lines_next;
    logic [STRIDE_W-1:0]    stride_reg, stride_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic [ALIGN_W-1:0]     align_eff;
    logic [BITS_W-1:0]      cur_bits;
    logic                   cur_div2;
    logic [19:0]            width_bits;
    logic [16:0]            bytes_raw;
    logic [BPL_W-1:0]       bpl_calc;
    logic                   rem_done;
    logic [ALIGN_W-1:0]     rem_val;
    logic [2:0]             plane_count;
    logic                   last_plane;
    logic                   out_free;
    logic                   in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg <= ALIGN_W'(1);
        end else if (cfg_valid) begin
            align_reg <= cfg_data;
        end
    end

    assign align_eff = (align_reg == '0) ? ALIGN_W'(1) : align_reg;

    // Line length of the current plane: bits are rounded up to whole bytes,
    // then doubled for planes that are vertically subsampled by two.
    assign cur_bits   = fmt_reg.bits[plane_reg];
    assign cur_div2   = fmt_reg.div2[plane_reg];
    assign width_bits = 20'(width_reg) * 20'(cur_bits);
    assign bytes_raw  = 17'((width_bits + 20'd7) >> 3);
    assign bpl_calc   = cur_div2 ? BPL_W'({bytes_raw, 1'b0}) : BPL_W'(bytes_raw);

    iplc_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (state_reg == S_START),
        .dividend  (bpl_calc),
        .divisor   (align_eff),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // Results per request are capped at MAX_PLANES.
    assign plane_count = (3'(fmt_reg.comps) < PLANE_CAP) ? 3'(fmt_reg.comps) : PLANE_CAP;
    assign last_plane  = ((3'(plane_reg) + 3'd1) == plane_count);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign in_take     = s_tvalid && (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        fmt_next      = fmt_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        plane_next    = plane_reg;
        bpl_next      = bpl_reg;
        lines_next    = lines_reg;
        stride_next   = stride_reg;
        prod_next     = prod_reg;
        offset_next   = offset_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    fmt_next    = lookup_fmt(s_tdata[FMT_W-1:0]);
                    width_next  = s_tdata[FMT_W +: DIM_W];
                    height_next = s_tdata[FMT_W+DIM_W +: DIM_W];
                    plane_next  = '0;
                    offset_next = '0;
                    state_next  = fmt_next.known ? S_START : S_ERR;
                end
            end
            S_START: begin
                bpl_next   = bpl_calc;
                lines_next = cur_div2 ? (height_reg >> 1) : height_reg;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (rem_done) begin
                    if (rem_val == '0) begin
                        stride_next = STRIDE_W'(bpl_reg);
                    end else begin
                        stride_next = STRIDE_W'(bpl_reg) + STRIDE_W'(align_eff)
                                    - STRIDE_W'(rem_val);
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(stride_reg) * PROD_W'(lines_reg);
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, fmt_reg.comps, fmt_reg.phys, lines_reg,
                                     stride_reg, bpl_reg, offset_reg, plane_reg};
                    m_tlast_next  = last_plane;
                    m_tuser_next  = 1'b0;
                    // Separate component planes share one allocation only when
                    // the plane counts differ; then they are laid end to end.
                    if (fmt_reg.comps != fmt_reg.phys) begin
                        offset_next = offset_reg + prod_reg[OFFSET_W-1:0];
                    end
                    if (last_plane) begin
                        state_next = S_IDLE;
                    end else begin
                        plane_next = plane_reg + PLANE_W'(1);
                        state_next = S_START;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fmt_reg     <= fmt_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
        plane_reg   <= plane_next;
        bpl_reg     <= bpl_next;
        lines_reg   <= lines_next;
        stride_reg  <= stride_next;
        prod_reg    <= prod_next;
        offset_reg  <= offset_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ----- rtl/core/iplc_rem_unit.sv -----
// Iterative restoring remainder unit: one dividend bit per cycle.
module iplc_rem_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [iplc_pkg::BPL_W-1:0]    dividend,
    input  logic [iplc_pkg::ALIGN_W-1:0]  divisor,
    output logic                          done,
    output logic [iplc_pkg::ALIGN_W-1:0]  remainder
);
    import iplc_pkg::*;

    localparam int CNT_W = $clog2(BPL_W + 1);

    logic [BPL_W-1:0]   dvd_reg, dvd_next;
    logic [ALIGN_W:0]   rem_reg, rem_next;
    logic [ALIGN_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ALIGN_W:0]   trial;

    // The partial remainder stays below the divisor, so one shifted bit fits.
    assign trial = {rem_reg[ALIGN_W-1:0], dvd_reg[BPL_W-1]};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(BPL_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[BPL_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[ALIGN_W-1:0];

endmodule
